[design/tga_rle_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the TGA run-length pixel decoder.
package tga_rle_pkg;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int QUEUE_DEPTH     = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_RLE_MODE        = 8'd0,
      REG_BYTES_PER_PIXEL = 8'd1,
      REG_IMAGE_WIDTH     = 8'd2,
      REG_IMAGE_HEIGHT    = 8'd3
   } csr_reg_type;

   // One decoded pixel as it travels from the front end to the back end.
   typedef struct packed {
      logic [23:0] pixel_bytes;
      logic        is_555;
      logic [7:0]  copies;
      logic        last_pixel;
   } pix_rec_type;

endpackage

[design/tga_rle_ifs.sv]
`timescale 1ns / 1ps
// Channel interfaces for the byte input, pixel output and register write ports.
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] copies;
   logic       last_pixel;
   modport source (output valid, output red, output green, output blue, output copies,
                   output last_pixel, input ready);
   modport sink   (input valid, input red, input green, input blue, input copies,
                   input last_pixel, output ready);
endinterface

interface tga_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/tga_rle_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, packet parsing, byte assembly and pixel counting.
module tga_rle_front (
   input  logic                     clock,
   input  logic                     reset,
   tga_req_if.sink                  req_bus,
   tga_csr_if.sink                  csr_bus,
   input  logic                     queue_full,
   output logic                     push,
   output tga_rle_pkg::pix_rec_type push_rec
);
   import tga_rle_pkg::*;

   logic        rle_mode_ff, rle_mode_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] total_ff, total_in;
   logic        expect_ff, expect_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] pb_ff, pb_in;
   logic        repeat_ff, repeat_in;
   logic [7:0]  remain_ff, remain_in;
   logic [31:0] left_ff, left_in;

   logic        accept;
   logic        csr_write;
   logic        csr_known;
   logic [1:0]  last_pos;
   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] product;
   logic        new_rle;
   logic [23:0] pb_new;
   logic [7:0]  copies_raw;
   logic [7:0]  copies;
   logic [31:0] left_after;
   logic        last;

   // A byte is held off while a register write is offered, so none is dropped by a restart.
   assign req_bus.ready = !queue_full && !csr_bus.valid;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   // Stored pixel size as the index of its final byte; odd settings clamp to 2 or 4 bytes.
   always_comb begin
      if (bpp_ff < 3'd3) begin
         last_pos = 2'd1;
      end else if (bpp_ff > 3'd4) begin
         last_pos = 2'd3;
      end else begin
         last_pos = 2'(bpp_ff - 3'd1);
      end
   end

   // The pixel count is formed from the incoming value and the other dimension,
   // so a restart has the new total ready in the cycle after the write.
   always_comb begin
      csr_known = 1'b1;
      mul_a     = width_ff;
      mul_b     = height_ff;
      new_rle   = rle_mode_ff;
      unique case (csr_bus.index)
         REG_RLE_MODE:        new_rle = csr_bus.data[0];
         REG_BYTES_PER_PIXEL: ;
         REG_IMAGE_WIDTH:     mul_a = csr_bus.data;
         REG_IMAGE_HEIGHT:    mul_b = csr_bus.data;
         default:             csr_known = 1'b0;
      endcase
   end

   assign product = mul_a * mul_b;

   always_comb begin
      pb_new = (pos_ff == 2'd0) ? 24'd0 : pb_ff;
      case (pos_ff)
         2'd0:    pb_new[7:0]   = req_bus.data_byte;
         2'd1:    pb_new[15:8]  = req_bus.data_byte;
         2'd2:    pb_new[23:16] = req_bus.data_byte;
         default: ;
      endcase
   end

   always_comb begin
      copies_raw = (rle_mode_ff && repeat_ff) ? remain_ff : 8'd1;
      if (copies_raw == 8'd0) begin
         copies_raw = 8'd1;
      end
      copies = ({24'd0, copies_raw} > left_ff) ? left_ff[7:0] : copies_raw;
      left_after = left_ff - {24'd0, copies};
      last = (left_after == 32'd0);
   end

   always_comb begin
      rle_mode_in = rle_mode_ff;
      bpp_in      = bpp_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      total_in    = total_ff;
      expect_in   = expect_ff;
      pos_in      = pos_ff;
      pb_in       = pb_ff;
      repeat_in   = repeat_ff;
      remain_in   = remain_ff;
      left_in     = left_ff;
      push        = 1'b0;

      if (csr_write) begin
         if (csr_known) begin
            unique case (csr_bus.index)
               REG_RLE_MODE:        rle_mode_in = csr_bus.data[0];
               REG_BYTES_PER_PIXEL: bpp_in = csr_bus.data[2:0];
               REG_IMAGE_WIDTH:     width_in = csr_bus.data;
               REG_IMAGE_HEIGHT:    height_in = csr_bus.data;
               default:             ;
            endcase
            total_in  = product;
            expect_in = new_rle;
            pos_in    = 2'd0;
            pb_in     = 24'd0;
            repeat_in = 1'b0;
            remain_in = 8'd0;
            left_in   = product;
         end
      end else if (accept && left_ff != 32'd0) begin
         if (rle_mode_ff && expect_ff) begin
            repeat_in = req_bus.data_byte[7];
            remain_in = {1'b0, req_bus.data_byte[6:0]} + 8'd1;
            expect_in = 1'b0;
            pos_in    = 2'd0;
         end else if (pos_ff < last_pos) begin
            pb_in  = pb_new;
            pos_in = pos_ff + 2'd1;
         end else begin
            push   = 1'b1;
            pb_in  = pb_new;
            pos_in = 2'd0;
            left_in = left_after;
            if (rle_mode_ff) begin
               if (repeat_ff || remain_ff == 8'd0) begin
                  remain_in = 8'd0;
               end else begin
                  remain_in = remain_ff - 8'd1;
               end
               if (remain_in == 8'd0) begin
                  expect_in = 1'b1;
               end
            end
            // Finishing the image drops any rest of the packet and starts over.
            if (last) begin
               expect_in = rle_mode_ff;
               pb_in     = 24'd0;
               repeat_in = 1'b0;
               remain_in = 8'd0;
               left_in   = total_ff;
            end
         end
      end
   end

   assign push_rec.pixel_bytes = pb_new;
   assign push_rec.is_555      = (last_pos == 2'd1);
   assign push_rec.copies      = copies;
   assign push_rec.last_pixel  = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_mode_ff <= 1'b0;
         bpp_ff      <= 3'd3;
         width_ff    <= 16'd1;
         height_ff   <= 16'd1;
         total_ff    <= 32'd1;
         expect_ff   <= 1'b0;
         pos_ff      <= 2'd0;
         pb_ff       <= 24'd0;
         repeat_ff   <= 1'b0;
         remain_ff   <= 8'd0;
         left_ff     <= 32'd1;
      end else begin
         rle_mode_ff <= rle_mode_in;
         bpp_ff      <= bpp_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         total_ff    <= total_in;
         expect_ff   <= expect_in;
         pos_ff      <= pos_in;
         pb_ff       <= pb_in;
         repeat_ff   <= repeat_in;
         remain_ff   <= remain_in;
         left_ff     <= left_in;
      end
   end

endmodule

[design/tga_rle_queue.sv]
`timescale 1ns / 1ps
// Small first-in first-out queue of decoded pixels between the front and back ends.
module tga_rle_queue #(
   parameter int Depth = tga_rle_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tga_rle_pkg::pix_rec_type push_rec,
   input  logic                     pop,
   output tga_rle_pkg::pix_rec_type pop_rec,
   output logic                     full,
   output logic                     empty
);
   import tga_rle_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   pix_rec_type           store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] ptr);
      return (ptr == PtrWidth'(Depth - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full    = (count_ff == CountWidth'(Depth));
   assign empty   = (count_ff == '0);
   assign pop_rec = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

[design/tga_rle_back.sv]
`timescale 1ns / 1ps
// Back end: color expansion of queued pixels and the registered result stage.
module tga_rle_back (
   input  logic                     clock,
   input  logic                     reset,
   input  tga_rle_pkg::pix_rec_type pop_rec,
   input  logic                     queue_empty,
   output logic                     pop,
   tga_rsp_if.source                rsp_bus
);
   import tga_rle_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] copies_ff;
   logic       last_ff;
   logic [7:0] p0, p1, p2;

   assign p0 = pop_rec.pixel_bytes[7:0];
   assign p1 = pop_rec.pixel_bytes[15:8];
   assign p2 = pop_rec.pixel_bytes[23:16];

   assign pop      = !queue_empty && (!valid_ff || rsp_bus.ready);
   assign valid_in = pop || (valid_ff && !rsp_bus.ready);

   // A 5-5-5 pixel is stored little endian: ARRRRRGG GGGBBBBB.
   always_comb begin
      if (pop_rec.is_555) begin
         red_in   = {p1[6:2], 3'b000};
         green_in = {p1[1:0], p0[7:5], 3'b000};
         blue_in  = {p0[4:0], 3'b000};
      end else begin
         red_in   = p2;
         green_in = p1;
         blue_in  = p0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         copies_ff <= pop_rec.copies;
         last_ff   <= pop_rec.last_pixel;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.red        = red_ff;
   assign rsp_bus.green      = green_ff;
   assign rsp_bus.blue       = blue_ff;
   assign rsp_bus.copies     = copies_ff;
   assign rsp_bus.last_pixel = last_ff;

endmodule

[design/tga_rle_pixel_decoder_unit.sv]
`timescale 1ns / 1ps
// Top level of the TGA run-length pixel decoder.
//
//   Channel   Direction  Payload                                 Transaction
//   req_bus   in         data_byte                               one image-data byte
//   rsp_bus   out        red, green, blue, copies, last_pixel    one decoded pixel
//   csr_bus   in         index, data                             one register write
//
// One byte is taken every cycle while the pixel queue has room and no register
// write is offered; a pixel is stored in a two-entry queue and then moves to an
// output register in the back end, so a stalled result side holds input only
// once both fill.
// Synchronous reset clears the control state and loads the register defaults.
// A register write restarts the image; the new pixel total is valid the next cycle.
module tga_rle_pixel_decoder_unit #(
   parameter int QueueDepth = tga_rle_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   tga_req_if.sink    req_bus,
   tga_rsp_if.source  rsp_bus,
   tga_csr_if.sink    csr_bus
);
   import tga_rle_pkg::*;

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   pix_rec_type q_push_rec;
   pix_rec_type q_pop_rec;

   tga_rle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (q_full),
      .push       (q_push),
      .push_rec   (q_push_rec)
   );

   tga_rle_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_push_rec),
      .pop      (q_pop),
      .pop_rec  (q_pop_rec),
      .full     (q_full),
      .empty    (q_empty)
   );

   tga_rle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_rec     (q_pop_rec),
      .queue_empty (q_empty),
      .pop         (q_pop),
      .rsp_bus     (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("pixel pushed into a full queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_empty || $past(q_pop))
      else $error("queued pixel went missing");

   a_copies_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.copies != 8'd0)
      else $error("result carries a zero copy count");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue reports full and empty together");
`endif

endmodule
